FILE: rtl/core/gnll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnll_pkg
// Shared types, codes and helper functions of the Gaussian NLL gradient block.
// ----------------------------------------------------------------------------
package gnll_pkg;

    localparam int Q_W       = 32;
    localparam int WIDE_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 31;
    localparam int CNT_W     = 16;
    localparam int IDX_W     = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_WITH_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LIMIT  = 2'd2;

    // Steps of the shared multiply-divide unit.
    typedef enum logic [3:0] {
        ST_H1, ST_H2, ST_GM, ST_SS, ST_DD, ST_G1, ST_G2, ST_G3, ST_GS,
        ST_KM, ST_KR, ST_KS, ST_CM, ST_CS
    } step_t;

    typedef enum logic [2:0] {
        C_IDLE, C_DECODE, C_ISSUE, C_WAIT, C_STORE, C_RDATA, C_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MD_IDLE, MD_MUL, MD_CHECK, MD_DIV
    } md_phase_t;

    typedef struct packed {
        logic  capture;
        logic  load_init;
        logic  read_begin;
        step_t step;
        logic  md_start;
        logic  md_capture;
        logic  store;
        logic  read_data;
        logic  out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic op;
        logic with_target;
        logic full;
        logic oor;
        logic clip_active;
        logic md_done;
        logic out_free;
    } dp_status_t;

    function automatic step_t next_step(step_t s);
        step_t n;
        n = ST_H1;
        unique case (s)
            ST_H1:   n = ST_H2;
            ST_H2:   n = ST_GM;
            ST_GM:   n = ST_SS;
            ST_SS:   n = ST_DD;
            ST_DD:   n = ST_G1;
            ST_G1:   n = ST_G2;
            ST_G2:   n = ST_G3;
            ST_G3:   n = ST_GS;
            ST_KM:   n = ST_KR;
            ST_KR:   n = ST_KS;
            ST_CM:   n = ST_CS;
            default: n = ST_H1;
        endcase
        return n;
    endfunction

    function automatic logic step_is_last(step_t s);
        return (s == ST_GS) || (s == ST_KS) || (s == ST_CS);
    endfunction

    function automatic logic step_mul_only(step_t s);
        return (s == ST_SS) || (s == ST_DD);
    endfunction

    // Signed saturation of a sign and magnitude pair to 32 bits.
    function automatic logic [Q_W-1:0] sat32(logic neg, logic [WIDE_W-1:0] mag);
        logic [Q_W-1:0] r;
        if (neg) begin
            if (mag >= 64'h0000_0000_8000_0000) begin
                r = 32'h8000_0000;
            end else begin
                r = ~mag[Q_W-1:0] + 32'd1;
            end
        end else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) begin
                r = 32'h7FFF_FFFF;
            end else begin
                r = mag[Q_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic logic [Q_W-1:0] abs32(logic [Q_W-1:0] v);
        return v[Q_W-1] ? (~v + 32'd1) : v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/gnll_item_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnll_item_if
// Request channel: one load or read request per handshake.
// ----------------------------------------------------------------------------
interface gnll_item_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic               start_req;
    logic signed [31:0] mean;
    logic signed [31:0] spread;
    logic signed [31:0] target;
    logic signed [31:0] weight;
    logic [11:0]        index;

    modport source (output valid, op, start_req, mean, spread, target, weight, index,
                    input ready);
    modport sink   (input valid, op, start_req, mean, spread, target, weight, index,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/core/gnll_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnll_result_if
// Result channel: one gradient pair per read request.
// ----------------------------------------------------------------------------
interface gnll_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] grad_mean;
    logic signed [31:0] grad_spread;
    logic               clipped;
    logic               out_of_range;

    modport source (output valid, grad_mean, grad_spread, clipped, out_of_range,
                    input ready);
    modport sink   (input valid, grad_mean, grad_spread, clipped, out_of_range,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/core/gnll_muldiv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnll_muldiv
// Computes floor(a*b/c) (or a*b when mul_only) over a 128-bit product: four
// 32x32 partial products, then a restoring divide at one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gnll_muldiv (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        mul_only,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    input  wire logic [63:0] c,
    output logic             done,
    output logic [63:0]      q
);
    import gnll_pkg::*;

    md_phase_t    phase_reg, phase_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic         done_reg, done_next;
    logic [63:0]  a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic         mo_reg, mo_next;
    logic [63:0]  pp_reg, pp_next;
    logic [1:0]   sh_reg, sh_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  rem_reg, rem_next;
    logic [63:0]  q_reg, q_next;

    logic [31:0]  a_half, b_half;
    logic [127:0] pp_ext, pp_shifted;
    logic [64:0]  trial;
    logic [64:0]  trial_sub;
    logic         trial_ge;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            MD_IDLE:  if (start) phase_next = MD_MUL;
            MD_MUL:   if (cnt_reg == 6'd4) phase_next = MD_CHECK;
            MD_CHECK:
            begin
                if (mo_reg || c_reg == 64'd0 || acc_reg[127:64] >= c_reg) begin
                    phase_next = MD_IDLE;
                end else begin
                    phase_next = MD_DIV;
                end
            end
            MD_DIV:   if (cnt_reg == 6'd0) phase_next = MD_IDLE;
            default:  phase_next = MD_IDLE;
        endcase
    end

    always_comb
    begin
        a_half     = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_half     = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp_ext     = {64'd0, pp_reg};
        pp_shifted = (sh_reg == 2'd0) ? pp_ext :
                     (sh_reg == 2'd1) ? (pp_ext << 32) : (pp_ext << 64);
        trial      = {rem_reg, acc_reg[63]};
        trial_ge   = trial >= {1'b0, c_reg};
        trial_sub  = trial - {1'b0, c_reg};

        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        mo_next   = mo_reg;
        cnt_next  = cnt_reg;
        pp_next   = pp_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        done_next = 1'b0;

        unique case (phase_reg)
            MD_IDLE:
            begin
                if (start) begin
                    a_next   = a;
                    b_next   = b;
                    c_next   = c;
                    mo_next  = mul_only;
                    cnt_next = 6'd0;
                    pp_next  = 64'd0;
                    sh_next  = 2'd0;
                    acc_next = 128'd0;
                end
            end
            MD_MUL:
            begin
                // Each cycle adds the previous partial product and forms the next.
                acc_next = acc_reg + pp_shifted;
                pp_next  = {32'd0, a_half} * {32'd0, b_half};
                sh_next  = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                cnt_next = cnt_reg + 6'd1;
            end
            MD_CHECK:
            begin
                if (mo_reg) begin
                    q_next    = acc_reg[63:0];
                    done_next = 1'b1;
                end else if (c_reg == 64'd0 || acc_reg[127:64] >= c_reg) begin
                    q_next    = {64{1'b1}};
                    done_next = 1'b1;
                end else begin
                    rem_next = acc_reg[127:64];
                    q_next   = 64'd0;
                    cnt_next = 6'd63;
                end
            end
            MD_DIV:
            begin
                rem_next = trial_ge ? trial_sub[63:0] : trial[63:0];
                q_next   = {q_reg[62:0], trial_ge};
                acc_next = {acc_reg[127:64], acc_reg[62:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    done_next = 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= MD_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= 6'd0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        mo_reg  <= mo_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule
`default_nettype wire

FILE: rtl/core/gnll_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnll_datapath
// Configuration registers, request latch, gradient store, running maximum,
// operand selection for the multiply-divide unit and the result register.
// ----------------------------------------------------------------------------
module gnll_datapath #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [gnll_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gnll_pkg::CFG_DAT_W-1:0] cfg_wdata,
    input  wire logic                          in_op,
    input  wire logic                          in_start_req,
    input  wire logic [31:0]                   in_mean,
    input  wire logic [31:0]                   in_spread,
    input  wire logic [31:0]                   in_target,
    input  wire logic [31:0]                   in_weight,
    input  wire logic [11:0]                   in_index,
    input  wire gnll_pkg::dp_cmd_t             cmd,
    output gnll_pkg::dp_status_t               status,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [31:0]                        out_grad_mean,
    output logic [31:0]                        out_grad_spread,
    output logic                               out_clipped,
    output logic                               out_oor
);
    import gnll_pkg::*;

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
    localparam logic [63:0] EPS = (ONE + 64'd50) / 64'd100;
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ELEMENTS);

    // Configuration.
    logic              with_target_reg;
    logic [CNT_W-1:0]  item_count_reg;
    logic [CFG_DAT_W-1:0] clip_limit_reg;

    // Latched request.
    logic        op_reg, start_reg;
    logic [31:0] mean_reg, spread_reg, target_reg, weight_reg;
    logic [11:0] index_reg;

    // Per-element working values.
    logic [31:0] s_reg, dm_reg, wm_reg, mum_reg;
    logic        dneg_reg, dzero_reg, wneg_reg, muneg_reg, ssltdd_reg;
    logic [63:0] t0_reg, t1_reg;
    logic [31:0] gm_reg, gs_reg;

    logic [CW-1:0] loaded_reg;
    logic [31:0]   largest_reg;

    logic [63:0] grad_mem [MAX_ELEMENTS];
    logic [63:0] rd_reg;

    logic [31:0] res_gm_reg, res_gs_reg;
    logic        res_clip_reg, res_oor_reg;

    logic        out_valid_reg;
    logic [31:0] out_gm_reg, out_gs_reg;
    logic        out_clip_reg, out_oor_reg;

    // Multiply-divide unit connection.
    logic        md_done;
    logic [63:0] md_q, md_a, md_b, md_c;

    logic [31:0] sp_mag, s_floor;
    logic [32:0] d_wide;
    logic [31:0] d_mag;
    logic [63:0] s_wide, den, diff, inner_mag;
    logic        inner_neg;
    logic [CNT_W-1:0] n_eff;
    logic [31:0] am, as_mag, max_ga;
    logic [XW-1:0] idx_x, loaded_x;
    logic        full, oor, clip_active;

    always_comb
    begin
        sp_mag   = abs32(spread_reg);
        s_floor  = (sp_mag < EPS[31:0]) ? EPS[31:0] : sp_mag;
        d_wide   = {target_reg[31], target_reg} - {mean_reg[31], mean_reg};
        d_mag    = d_wide[32] ? 32'(~d_wide + 33'd1) : d_wide[31:0];
        s_wide   = {32'd0, s_reg};
        n_eff    = (item_count_reg == '0) ? CNT_W'(1) : item_count_reg;
        den      = {48'd0, n_eff} << FRAC_BITS;
        diff     = (t0_reg >= t1_reg) ? (t0_reg - t1_reg) : (t1_reg - t0_reg);
        inner_neg = t0_reg > s_wide;
        inner_mag = inner_neg ? (t0_reg - s_wide) : (s_wide - t0_reg);
        am       = abs32(gm_reg);
        as_mag   = abs32(gs_reg);
        max_ga   = (am > as_mag) ? am : as_mag;
        idx_x    = XW'(index_reg);
        loaded_x = XW'(loaded_reg);
        full     = !start_reg && (loaded_reg == FULL_COUNT);
        oor      = idx_x >= loaded_x;
        clip_active = (clip_limit_reg != '0) && (largest_reg > {1'b0, clip_limit_reg});
    end

    always_comb
    begin
        md_a = 64'd0;
        md_b = ONE;
        md_c = s_wide;
        unique case (cmd.step)
            ST_H1: md_a = {32'd0, dm_reg};
            ST_H2: md_a = t0_reg;
            ST_GM:
            begin
                md_a = {32'd0, wm_reg};
                md_b = t0_reg;
                md_c = den;
            end
            ST_SS:
            begin
                md_a = s_wide;
                md_b = s_wide;
            end
            ST_DD:
            begin
                md_a = {32'd0, dm_reg};
                md_b = {32'd0, dm_reg};
            end
            ST_G1: md_a = diff;
            ST_G2: md_a = t0_reg;
            ST_G3:
            begin
                md_a = t0_reg;
                md_b = 64'd1;
            end
            ST_GS:
            begin
                md_a = {32'd0, wm_reg};
                md_b = t0_reg;
                md_c = den;
            end
            ST_KM:
            begin
                md_a = {32'd0, wm_reg};
                md_b = {32'd0, mum_reg};
                md_c = den;
            end
            ST_KR: md_a = ONE;
            ST_KS:
            begin
                md_a = {32'd0, wm_reg};
                md_b = inner_mag;
                md_c = den;
            end
            ST_CM:
            begin
                md_a = {32'd0, abs32(res_gm_reg)};
                md_b = {33'd0, clip_limit_reg};
                md_c = {32'd0, largest_reg};
            end
            ST_CS:
            begin
                md_a = {32'd0, abs32(res_gs_reg)};
                md_b = {33'd0, clip_limit_reg};
                md_c = {32'd0, largest_reg};
            end
            default: md_a = 64'd0;
        endcase
    end

    gnll_muldiv u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.md_start),
        .mul_only (step_mul_only(cmd.step)),
        .a        (md_a),
        .b        (md_b),
        .c        (md_c),
        .done     (md_done),
        .q        (md_q)
    );

    // Control state: configuration, counters, valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            with_target_reg <= 1'b1;
            item_count_reg  <= CNT_W'(1);
            clip_limit_reg  <= '0;
            op_reg          <= 1'b0;
            start_reg       <= 1'b0;
            loaded_reg      <= '0;
            largest_reg     <= 32'd0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_WITH_TARGET: with_target_reg <= cfg_wdata[0];
                    CFG_ITEM_COUNT:  item_count_reg  <= cfg_wdata[CNT_W-1:0];
                    CFG_CLIP_LIMIT:  clip_limit_reg  <= cfg_wdata;
                    default:         with_target_reg <= with_target_reg;
                endcase
            end
            if (cmd.capture) begin
                op_reg    <= in_op;
                start_reg <= in_start_req;
            end
            if (cmd.load_init && start_reg) begin
                loaded_reg  <= '0;
                largest_reg <= 32'd0;
            end
            if (cmd.store) begin
                loaded_reg <= loaded_reg + CW'(1);
                if (max_ga > largest_reg) begin
                    largest_reg <= max_ga;
                end
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture) begin
            mean_reg   <= in_mean;
            spread_reg <= in_spread;
            target_reg <= in_target;
            weight_reg <= in_weight;
            index_reg  <= in_index;
        end
        if (cmd.load_init) begin
            s_reg     <= s_floor;
            dm_reg    <= d_mag;
            dneg_reg  <= d_wide[32];
            dzero_reg <= (d_wide == 33'd0);
            wm_reg    <= abs32(weight_reg);
            wneg_reg  <= weight_reg[31];
            mum_reg   <= abs32(mean_reg);
            muneg_reg <= mean_reg[31];
        end
        if (cmd.md_capture) begin
            unique case (cmd.step)
                ST_DD: t1_reg <= md_q;
                ST_G1:
                begin
                    ssltdd_reg <= t0_reg < t1_reg;
                    t0_reg     <= md_q;
                end
                ST_GM:
                begin
                    gm_reg <= dzero_reg ? 32'd0 : sat32(wneg_reg == dneg_reg, md_q);
                end
                ST_GS: gs_reg <= sat32(wneg_reg != ssltdd_reg, md_q);
                ST_KM: gm_reg <= sat32(wneg_reg != muneg_reg, md_q);
                ST_KS: gs_reg <= sat32(wneg_reg != inner_neg, md_q);
                ST_CM:
                begin
                    res_gm_reg   <= sat32(res_gm_reg[31], md_q);
                    res_clip_reg <= 1'b1;
                end
                ST_CS: res_gs_reg <= sat32(res_gs_reg[31], md_q);
                default: t0_reg <= md_q;
            endcase
        end
        if (cmd.store) begin
            grad_mem[loaded_reg[AW-1:0]] <= {gm_reg, gs_reg};
        end
        if (cmd.read_begin) begin
            rd_reg       <= grad_mem[idx_x[AW-1:0]];
            res_gm_reg   <= 32'd0;
            res_gs_reg   <= 32'd0;
            res_clip_reg <= 1'b0;
            res_oor_reg  <= oor;
        end
        if (cmd.read_data) begin
            res_gm_reg <= rd_reg[63:32];
            res_gs_reg <= rd_reg[31:0];
        end
        if (cmd.out_load) begin
            out_gm_reg   <= res_gm_reg;
            out_gs_reg   <= res_gs_reg;
            out_clip_reg <= res_clip_reg;
            out_oor_reg  <= res_oor_reg;
        end
    end

    always_comb
    begin
        status.op          = op_reg;
        status.with_target = with_target_reg;
        status.full        = full;
        status.oor         = oor;
        status.clip_active = clip_active;
        status.md_done     = md_done;
        status.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign out_grad_mean   = out_gm_reg;
    assign out_grad_spread = out_gs_reg;
    assign out_clipped     = out_clip_reg;
    assign out_oor         = out_oor_reg;

endmodule
`default_nettype wire

FILE: rtl/core/gnll_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnll_ctrl
// Sequencer: takes a request, walks the multiply-divide steps of the selected
// mode, then stores a load's result or hands a read's to the output register.
// ----------------------------------------------------------------------------
module gnll_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire gnll_pkg::dp_status_t status,
    output gnll_pkg::dp_cmd_t         cmd
);
    import gnll_pkg::*;

    ctrl_state_t state_reg, state_next;
    step_t       step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (in_valid) state_next = C_DECODE;
            end
            C_DECODE:
            begin
                if (status.op) begin
                    state_next = status.oor ? C_OUT : C_RDATA;
                end else if (status.full) begin
                    state_next = C_IDLE;
                end else begin
                    state_next = C_ISSUE;
                    step_next  = status.with_target ? ST_H1 : ST_KM;
                end
            end
            C_ISSUE: state_next = C_WAIT;
            C_WAIT:
            begin
                if (status.md_done) begin
                    if (step_is_last(step_reg)) begin
                        state_next = status.op ? C_OUT : C_STORE;
                    end else begin
                        state_next = C_ISSUE;
                        step_next  = next_step(step_reg);
                    end
                end
            end
            C_STORE: state_next = C_IDLE;
            C_RDATA:
            begin
                if (status.clip_active) begin
                    state_next = C_ISSUE;
                    step_next  = ST_CM;
                end else begin
                    state_next = C_OUT;
                end
            end
            C_OUT:
            begin
                if (status.out_free) state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.step = step_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            C_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            C_DECODE:
            begin
                cmd.load_init  = !status.op;
                cmd.read_begin = status.op;
            end
            C_ISSUE:  cmd.md_start   = 1'b1;
            C_WAIT:   cmd.md_capture = status.md_done;
            C_STORE:  cmd.store      = 1'b1;
            C_RDATA:  cmd.read_data  = 1'b1;
            C_OUT:    cmd.out_load   = status.out_free;
            default:  in_ready       = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= C_IDLE;
            step_reg  <= ST_H1;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/gaussian_nll_gradient_clip.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_nll_gradient_clip
// Gaussian NLL / KL gradient engine with gradient store and norm clipping.
// ----------------------------------------------------------------------------
// One request is handled at a time. Every fixed-point step goes through a
// single shared multiply-divide unit that forms a plain product or a product
// followed by a division (one quotient bit per cycle). A load runs seven
// divisions and two products in target mode and three divisions in KL mode.
// A read runs two divisions only when clipping is active. A finished result
// waits in an output register, so a new request is taken while the previous
// result is still unclaimed. The gradient store has no reset; only entries
// loaded since the last batch start are read back.
// ----------------------------------------------------------------------------
module gaussian_nll_gradient_clip #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    gnll_item_if.sink                           items,
    gnll_result_if.source                       results,
    input  wire logic                           cfg_we,
    input  wire logic [gnll_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gnll_pkg::CFG_DAT_W-1:0] cfg_wdata
);
    import gnll_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;

    gnll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    gnll_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_op           (items.op),
        .in_start_req    (items.start_req),
        .in_mean         (items.mean),
        .in_spread       (items.spread),
        .in_target       (items.target),
        .in_weight       (items.weight),
        .in_index        (items.index),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (results.valid),
        .out_ready       (results.ready),
        .out_grad_mean   (results.grad_mean),
        .out_grad_spread (results.grad_spread),
        .out_clipped     (results.clipped),
        .out_oor         (results.out_of_range)
    );

    assign items.ready = in_ready;

endmodule
`default_nettype wire

FILE: rtl/core/gnll_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnll_checker
// Port-level checks of the gradient block, bound to the top level.
// ----------------------------------------------------------------------------
module gnll_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_valid,
    input wire logic        item_ready,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [31:0] grad_mean,
    input wire logic [31:0] grad_spread,
    input wire logic        clipped,
    input wire logic        out_of_range
);

    // A result stays offered until it is taken.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped before it was taken");

    // Only one request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("request taken while another is in progress");

    // An out-of-range read carries zero values and no clipping.
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_of_range |-> grad_mean == 32'd0 && grad_spread == 32'd0
                                      && !clipped)
        else $error("out-of-range result carries data");

    // A result is raised only while a request is in progress.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!item_ready))
        else $error("result appeared without work in progress");

endmodule

bind gaussian_nll_gradient_clip gnll_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (items.valid),
    .item_ready   (items.ready),
    .res_valid    (results.valid),
    .res_ready    (results.ready),
    .grad_mean    (results.grad_mean),
    .grad_spread  (results.grad_spread),
    .clipped      (results.clipped),
    .out_of_range (results.out_of_range)
);
`default_nettype wire

FILE: tb/gnll_grad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnll_grad_checker
// Watches the request, result and register ports of the gradient block. It
// keeps its own copy of the registers, the gradient store and the running
// maximum, predicts every read result and compares it field by field.
// ----------------------------------------------------------------------------
module gnll_grad_checker
    import gnll_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    gnll_item_if                 items,
    gnll_result_if               results,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    output int                   errors,
    output int                   pending
);

    localparam int          DEPTH = 4096;
    localparam logic [63:0] ONE   = 64'd65536;
    localparam logic [63:0] EPS   = 64'd655;

    typedef struct packed {
        logic [31:0] gm;
        logic [31:0] gs;
        logic        clipped;
        logic        oor;
    } grad_pair_t;

    grad_pair_t  expected_pairs[$];
    logic [31:0] mean_grads[DEPTH];
    logic [31:0] spread_grads[DEPTH];
    logic [31:0] peak_mag;
    int          loaded;
    logic        target_mode;
    logic [15:0] batch_size;
    logic [30:0] clip_lim;

    assign pending = expected_pairs.size();

    // floor(a*b/c) over an exact product, all ones when the quotient overflows
    function automatic logic [63:0] mul_div(logic [63:0] a, logic [63:0] b, logic [63:0] c);
        logic [127:0] p;
        logic [127:0] q;
        p = {64'd0, a} * {64'd0, b};
        if (c == 0 || p[127:64] >= c) return '1;
        q = p / {64'd0, c};
        return q[63:0];
    endfunction

    function automatic logic [63:0] mag(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [31:0] saturate(bit neg, logic [63:0] m);
        if (neg) return m >= 64'h8000_0000 ? 32'h8000_0000 : 32'(-m);
        return m > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : m[31:0];
    endfunction

    function automatic void predict_load(logic st, logic signed [31:0] mean_v,
                                         logic signed [31:0] spread_v,
                                         logic signed [31:0] target_v,
                                         logic signed [31:0] weight_v);
        logic [63:0] s, wm, den, dm, ss, dd, h2, diff, g3, am, as_m;
        logic [31:0] gm, gs;
        longint      mu, d, inner;
        bit          wneg;
        mu   = longint'(mean_v);
        s    = mag(longint'(spread_v));
        wm   = mag(longint'(weight_v));
        wneg = weight_v < 0;
        den  = ONE * (batch_size == 0 ? 64'd1 : 64'(batch_size));
        if (st) begin
            loaded   = 0;
            peak_mag = 0;
        end
        if (loaded >= DEPTH) return;
        if (s < EPS) s = EPS;
        if (target_mode) begin
            d    = longint'(target_v) - mu;
            dm   = mag(d);
            ss   = s * s;
            dd   = dm * dm;
            h2   = mul_div(mul_div(dm, ONE, s), ONE, s);
            diff = ss >= dd ? ss - dd : dd - ss;
            g3   = mul_div(mul_div(diff, ONE, s), ONE, s) / s;
            gm   = d == 0 ? 32'd0 : saturate(wneg == (d < 0), mul_div(wm, h2, den));
            gs   = saturate(wneg != (ss < dd), mul_div(wm, g3, den));
        end else begin
            inner = longint'(s) - longint'((64'd1 << 32) / s);
            gm    = saturate(wneg != (mu < 0), mul_div(wm, mag(mu), den));
            gs    = saturate(wneg != (inner < 0), mul_div(wm, mag(inner), den));
        end
        mean_grads[loaded]   = gm;
        spread_grads[loaded] = gs;
        loaded++;
        am   = mag(longint'($signed(gm)));
        as_m = mag(longint'($signed(gs)));
        if (am > peak_mag) peak_mag = am[31:0];
        if (as_m > peak_mag) peak_mag = as_m[31:0];
    endfunction

    function automatic grad_pair_t predict_read(logic [11:0] idx);
        grad_pair_t r;
        logic [31:0] gm, gs;
        r = '0;
        if (int'(idx) >= loaded) begin
            r.oor = 1'b1;
            return r;
        end
        gm = mean_grads[idx];
        gs = spread_grads[idx];
        if (clip_lim > 0 && peak_mag > {1'b0, clip_lim}) begin
            gm = saturate(gm[31], mul_div(mag(longint'($signed(gm))), 64'(clip_lim),
                                          64'(peak_mag)));
            gs = saturate(gs[31], mul_div(mag(longint'($signed(gs))), 64'(clip_lim),
                                          64'(peak_mag)));
            r.clipped = 1'b1;
        end
        r.gm = gm;
        r.gs = gs;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        grad_pair_t want;
        if (!rst_n) begin
            expected_pairs.delete();
            peak_mag    <= 0;
            loaded      = 0;
            target_mode <= 1'b1;
            batch_size  <= 16'd1;
            clip_lim    <= '0;
            errors      <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_WITH_TARGET: target_mode <= cfg_wdata[0];
                    CFG_ITEM_COUNT:  batch_size  <= cfg_wdata[15:0];
                    CFG_CLIP_LIMIT:  clip_lim    <= cfg_wdata[30:0];
                    default: ;
                endcase
            end
            if (items.valid && items.ready) begin
                if (items.op)
                    expected_pairs.insert(expected_pairs.size(),
                                          predict_read(items.index));
                else
                    predict_load(items.start_req, items.mean, items.spread,
                                 items.target, items.weight);
            end
            if (results.valid && results.ready) begin
                if (expected_pairs.size() == 0) begin
                    $display("%0t: result with nothing expected: %h %h %b %b", $time,
                             results.grad_mean, results.grad_spread, results.clipped,
                             results.out_of_range);
                    errors <= errors + 1;
                end else begin
                    want = expected_pairs.pop_front();
                    if (want != {results.grad_mean, results.grad_spread,
                                 results.clipped, results.out_of_range}) begin
                        $display("%0t: mismatch expected gm %h gs %h clip %b oor %b",
                                 $time, want.gm, want.gs, want.clipped, want.oor);
                        $display("%0t:            actual gm %h gs %h clip %b oor %b",
                                 $time, results.grad_mean, results.grad_spread,
                                 results.clipped, results.out_of_range);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the Gaussian NLL gradient block: directed corner requests,
// then random batches of loads and reads under several register settings
// and idle/stall patterns. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb;
    import gnll_pkg::*;

    localparam bit OP_LOAD = 1'b0;
    localparam bit OP_READ = 1'b1;
    localparam int DEPTH   = 4096;
    localparam int SETTLE  = 700;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_wdata;
    int                   errors;
    int                   pending;
    int                   idle_pct;
    int                   stall_pct;
    int                   loaded;

    gnll_item_if   items_bus();
    gnll_result_if results_bus();

    gaussian_nll_gradient_clip uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items_bus),
        .results   (results_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    gnll_grad_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items_bus),
        .results   (results_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        results_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            results_bus.ready <= $urandom_range(99) >= stall_pct;
        end
    end

    initial
    begin
        #60_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [31:0] rand_q();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            default: return $urandom_range(2) == 0 ? 32'd0 : $urandom_range(1) ? 32'd1 : '1;
        endcase
    endfunction

    task automatic send(bit op, bit st, logic [31:0] m, logic [31:0] sp,
                        logic [31:0] tg, logic [31:0] w, logic [11:0] idx);
        bit accepted;
        while ($urandom_range(99) < idle_pct)
        begin
            items_bus.valid <= 1'b0;
            @(posedge clk);
        end
        items_bus.valid     <= 1'b1;
        items_bus.op        <= op;
        items_bus.start_req <= st;
        items_bus.mean      <= m;
        items_bus.spread    <= sp;
        items_bus.target    <= tg;
        items_bus.weight    <= w;
        items_bus.index     <= idx;
        do
        begin
            @(negedge clk);
            accepted = items_bus.ready;
            @(posedge clk);
        end while (!accepted);
        if (op == OP_LOAD)
        begin
            if (st) loaded = 0;
            if (loaded < DEPTH) loaded++;
        end
    endtask

    task automatic load(bit st, logic [31:0] m, logic [31:0] sp, logic [31:0] tg,
                        logic [31:0] w);
        send(OP_LOAD, st, m, sp, tg, w, $urandom);
    endtask

    task automatic read(logic [11:0] idx, bit st = 1'b0);
        send(OP_READ, st, $urandom, $urandom, $urandom, $urandom, idx);
    endtask

    // Leaves the block idle: all results in and the last load given time to finish.
    task automatic settle();
        items_bus.valid <= 1'b0;
        cfg_we          <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(bit wt, logic [15:0] cnt, logic [30:0] clip);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WITH_TARGET;
        cfg_wdata <= 31'(wt);
        @(posedge clk);
        cfg_index <= CFG_ITEM_COUNT;
        cfg_wdata <= 31'(cnt);
        @(posedge clk);
        cfg_index <= CFG_CLIP_LIMIT;
        cfg_wdata <= clip;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_config();
        logic [15:0] cnt;
        logic [30:0] clip;
        case ($urandom_range(3))
            0: cnt = 16'd1;
            1: cnt = 16'hFFFF;
            2: cnt = 16'd0;
            default: cnt = $urandom_range(1, 8);
        endcase
        case ($urandom_range(3))
            0: clip = '0;
            1: clip = 31'h7FFF_FFFF;
            2: clip = $urandom_range(1, 1 << 17);
            default: clip = $urandom;
        endcase
        configure($urandom_range(1), cnt, clip);
    endtask

    task automatic random_batch(output int sent);
        int n;
        n = $urandom_range(2, 14);
        sent = n + 1;
        // A batch opens with a start request, then loads and reads interleave.
        load(1'b1, rand_q(), rand_q(), rand_q(), rand_q());
        for (int i = 1; i < n; i++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                    read((loaded > 0 && $urandom_range(9) < 8) ?
                         $urandom_range(loaded - 1) : $urandom_range(DEPTH - 1),
                         $urandom_range(3) == 0);
                4:  load($urandom_range(7) == 0, rand_q(), rand_q(), rand_q(), rand_q());
                default: load(1'b0, rand_q(), rand_q(), rand_q(), rand_q());
            endcase
        end
        read($urandom_range(loaded - 1));
    endtask

    initial
    begin
        int sent;
        int total;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_WITH_TARGET;
        cfg_wdata           = '0;
        items_bus.valid     = 1'b0;
        items_bus.op        = OP_LOAD;
        items_bus.start_req = 1'b0;
        items_bus.mean      = '0;
        items_bus.spread    = '0;
        items_bus.target    = '0;
        items_bus.weight    = '0;
        items_bus.index     = '0;
        idle_pct            = 0;
        stall_pct           = 0;
        loaded              = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners in target mode, no clipping.
        read(12'd0);
        settle();
        configure(1'b1, 16'd1, '0);
        load(1'b1, 32'd0, 32'd0, 32'd0, 32'h0001_0000);
        load(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        load(1'b0, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h8000_0000, 32'h8000_0000);
        load(1'b0, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'hFFFF_8000);
        read(12'd0);
        read(12'd1);
        read(12'd2);
        read(12'd3, 1'b1);
        read(12'd4);
        read(12'hFFF);
        settle();
        // Clipping with the smallest limit, and a zero item count.
        configure(1'b1, 16'd0, 31'd1);
        read(12'd1);
        read(12'd3);
        settle();
        // KL mode corners: spread of one, tiny spread, negative mean.
        configure(1'b0, 16'hFFFF, 31'h7FFF_FFFF);
        load(1'b1, 32'hFFFE_0000, 32'h0001_0000, 32'd0, 32'h0001_0000);
        load(1'b0, 32'h8000_0000, 32'd1, 32'd0, 32'h7FFF_FFFF);
        load(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h8000_0000);
        read(12'd0);
        read(12'd1);
        read(12'd2);
        read(12'd3);
        settle();

        total = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  configure(1'b1, 16'd1, '0); end
                1: begin idle_pct = 88; stall_pct = 0;  configure(1'b0, 16'd3, 31'h7FFF_FFFF); end
                2: begin idle_pct = 0;  stall_pct = 88; configure(1'b1, 16'hFFFF, 31'd1); end
                default: begin idle_pct = 21; stall_pct = 21; configure(1'b1, 16'd2, 31'h2_0000); end
            endcase
            while (total < 112 * (phase + 1))
            begin
                random_batch(sent);
                total += sent;
                if ($urandom_range(3) == 0)
                begin
                    settle();
                    random_config();
                end
            end
            settle();
        end

        settle();
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/gnll_pkg.sv
rtl/core/gnll_item_if.sv
rtl/core/gnll_result_if.sv
rtl/core/gnll_muldiv.sv
rtl/core/gnll_datapath.sv
rtl/core/gnll_ctrl.sv
rtl/core/gaussian_nll_gradient_clip.sv
rtl/core/gnll_checker.sv
tb/gnll_grad_checker.sv
tb/tb.sv
